### rtl/mtas_pkg.sv
package mtas_pkg;

  // fixed result widths
  localparam int AREA_W = 48;
  localparam int SUM_W  = 64;

  // occupancy of the queue between the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/mesh_triangle_area_sum_top.sv
// channel  | handshake          | payload
// in       | in_valid/in_ready  | in_vert_{a,b,c}_{x,y,z}, in_last_triangle
// out      | out_valid/out_ready| out_triangle_area, out_area_total,
//          |                    | out_total_saturated, out_is_final
//
// One triangle's time in the back part is set by the shared one-bit-per-cycle root
// unit and the shift-add multiplier. A two-entry queue takes input beats while the
// back part works.
// Reset (rst_n, synchronous) clears the queue, sequencer, running sum and flag.
// A held result beat stalls the back part only when the next result is ready.
module mesh_triangle_area_sum_top #(
  parameter int COORD_BITS      = 16,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       in_vert_a_x,
  input  logic signed [COORD_BITS-1:0]       in_vert_a_y,
  input  logic signed [COORD_BITS-1:0]       in_vert_a_z,
  input  logic signed [COORD_BITS-1:0]       in_vert_b_x,
  input  logic signed [COORD_BITS-1:0]       in_vert_b_y,
  input  logic signed [COORD_BITS-1:0]       in_vert_b_z,
  input  logic signed [COORD_BITS-1:0]       in_vert_c_x,
  input  logic signed [COORD_BITS-1:0]       in_vert_c_y,
  input  logic signed [COORD_BITS-1:0]       in_vert_c_z,
  input  logic                               in_last_triangle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mtas_pkg::AREA_W-1:0]        out_triangle_area,
  output logic [mtas_pkg::SUM_W-1:0]         out_area_total,
  output logic                               out_total_saturated,
  output logic                               out_is_final
);
  import mtas_pkg::*;

  localparam int QW = 9 * COORD_BITS + 1;

  logic [8:0][COORD_BITS-1:0] coord;
  logic                       push, pop;
  logic [QW-1:0]              push_data, q_data;
  q_stat_t                    q_stat;

  assign coord = {in_vert_c_z, in_vert_c_y, in_vert_c_x,
                  in_vert_b_z, in_vert_b_y, in_vert_b_x,
                  in_vert_a_z, in_vert_a_y, in_vert_a_x};

  mtas_front #(.CB(COORD_BITS)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .coord         (coord),
    .last_triangle (in_last_triangle),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  mtas_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (q_data),
    .stat  (q_stat)
  );

  mtas_core #(.CB(COORD_BITS), .FB(COORD_FRAC_BITS)) u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_data              (q_data),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_triangle_area   (out_triangle_area),
    .out_area_total      (out_area_total),
    .out_total_saturated (out_total_saturated),
    .out_is_final        (out_is_final)
  );

endmodule

### rtl/mtas_front.sv
module mtas_front #(
  parameter int CB = 16
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [8:0][CB-1:0]   coord,
  input  logic                 last_triangle,
  input  mtas_pkg::q_stat_t    q_stat,
  output logic                 push,
  output logic [9*CB:0]        push_data
);
  import mtas_pkg::*;

  logic [8:0][CB-1:0] absd;

  // accept a beat whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // per edge and axis, take the absolute coordinate difference
  // edges: first-second, first-third, third-second
  for (genvar e = 0; e < 3; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_axis
      localparam int P = (e == 2) ? 2 : 0;
      localparam int Q = (e == 0) ? 1 : ((e == 1) ? 2 : 1);
      logic signed [CB:0] diff;
      logic        [CB:0] mag;
      always_comb begin
        diff = $signed({coord[P*3+k][CB-1], coord[P*3+k]})
             - $signed({coord[Q*3+k][CB-1], coord[Q*3+k]});
        mag  = diff[CB] ? (~diff + 1'b1) : diff;
        absd[e*3+k] = mag[CB-1:0];
      end
    end
  end

  assign push_data = {last_triangle, absd};

endmodule

### rtl/mtas_fifo.sv
module mtas_fifo #(
  parameter int W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      wdata,
  input  logic              pop,
  output logic [W-1:0]      rdata,
  output mtas_pkg::q_stat_t stat
);
  import mtas_pkg::*;

  logic [W-1:0] mem [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = mem[rp_r];

  // store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

### rtl/mtas_sqrt.sv
module mtas_sqrt #(
  parameter int PW = 92,
  parameter int RW = PW / 2,
  parameter int NW = $clog2(RW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] rad,
  input  logic [NW-1:0] npairs,
  output logic          busy,
  output logic [RW-1:0] root
);
  import mtas_pkg::*;

  logic [PW-1:0] rad_r, rad_nxt;
  logic [RW+1:0] rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [NW-1:0] cnt_r;
  logic [RW+3:0] tmp, trial, rem_sub;

  assign busy = (cnt_r != '0);
  assign root = root_r;

  // one root bit per cycle, radicand consumed from its top two bits
  always_comb begin
    tmp     = {rem_r, rad_r[PW-1:PW-2]};
    trial   = {2'b00, root_r, 2'b01};
    rem_sub = tmp - trial;
    rad_nxt = rad_r << 2;
    if (tmp >= trial) begin
      rem_nxt  = rem_sub[RW+1:0];
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = tmp[RW+1:0];
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= npairs;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### rtl/mtas_core.sv
module mtas_core #(
  parameter int CB = 16,
  parameter int FB = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mtas_pkg::q_stat_t               q_stat,
  input  logic [9*CB:0]                   q_data,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mtas_pkg::AREA_W-1:0]     out_triangle_area,
  output logic [mtas_pkg::SUM_W-1:0]      out_area_total,
  output logic                            out_total_saturated,
  output logic                            out_is_final
);
  import mtas_pkg::*;

  localparam int LB = CB + FB + 1;   // edge length width
  localparam int SW = LB + 2;        // perimeter width
  localparam int PW = 4 * SW;        // Heron product width
  localparam int RW = PW / 2;
  localparam int NW = $clog2(RW + 1);
  localparam int MW = $clog2(SW + 1);
  localparam int EW = 2 * CB + 2;    // squared distance width
  localparam int ER = EW + 2 * FB;   // edge radicand width

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_ESS  = 4'd2;
  localparam logic [3:0] ST_EW   = 4'd3;
  localparam logic [3:0] ST_SUM  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_ASS  = 4'd6;
  localparam logic [3:0] ST_AW   = 4'd7;
  localparam logic [3:0] ST_RES  = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [8:0][CB-1:0]   d_r;
  logic                 last_r;
  logic [1:0]           e_r, e_nxt, k_r, k_nxt;
  logic [EW-1:0]        esum_r, esum_nxt;
  logic [2:0][LB-1:0]   len_r;
  logic [2:0][SW-1:0]   f_r;
  logic [1:0]           m_r, m_nxt;
  logic [PW-1:0]        macc_r, macc_nxt, mc_r, mc_nxt;
  logic [SW-1:0]        mp_r, mp_nxt;
  logic [MW-1:0]        mcnt_r, mcnt_nxt;
  logic [AREA_W-1:0]    area_r;
  logic [SUM_W-1:0]     acc_r;
  logic                 sat_r;

  logic [3:0]           d_idx;
  logic [2*CB-1:0]      sq;
  logic [SW-1:0]        s_c;
  logic [2:0][SW-1:0]   f_c;
  logic [PW-1:0]        macc_add;

  logic                 sq_start, sq_busy;
  logic [PW-1:0]        sq_rad;
  logic [NW-1:0]        sq_n;
  logic [RW-1:0]        sq_root;

  logic [RW+AREA_W-1:0] area_ext;
  logic [AREA_W-1:0]    area_c;
  logic [SUM_W:0]       sum_c;
  logic [SUM_W-1:0]     tot_c;
  logic                 sat_c, load_out;

  // shared iterative root unit
  mtas_sqrt #(.PW(PW)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .rad    (sq_rad),
    .npairs (sq_n),
    .busy   (sq_busy),
    .root   (sq_root)
  );

  // left-align the edge radicand; its low 2*FB bits are zero
  assign sq_start = (state_r == ST_ESS) || (state_r == ST_ASS);
  assign sq_rad   = (state_r == ST_ESS) ? ({{(PW-EW){1'b0}}, esum_r} << (PW - EW)) : macc_r;
  assign sq_n     = (state_r == ST_ESS) ? NW'(ER / 2) : NW'(RW);

  // squared distance of one axis
  assign d_idx = 4'(e_r) * 4'd3 + 4'(k_r);
  assign sq    = d_r[d_idx] * d_r[d_idx];

  // perimeter and clamped Heron factors
  always_comb begin
    s_c = SW'(len_r[0]) + SW'(len_r[1]) + SW'(len_r[2]);
    for (int i = 0; i < 3; i++) begin
      f_c[i] = (s_c > {len_r[i], 1'b0}) ? (s_c - {len_r[i], 1'b0}) : '0;
    end
  end

  assign macc_add = mp_r[0] ? (macc_r + mc_r) : macc_r;

  // drop the two fraction bits of the root and saturate to the area width
  always_comb begin
    area_ext = {{AREA_W{1'b0}}, sq_root} >> 2;
    area_c   = (|area_ext[RW+AREA_W-1:AREA_W]) ? '1 : area_ext[AREA_W-1:0];
  end

  // saturating running sum
  always_comb begin
    sum_c = {1'b0, acc_r} + {{(SUM_W-AREA_W+1){1'b0}}, area_r};
    tot_c = sum_c[SUM_W] ? '1 : sum_c[SUM_W-1:0];
    sat_c = sat_r || (tot_c == '1);
  end

  assign load_out = (state_r == ST_RES) && (!out_valid || out_ready);
  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    e_nxt     = e_r;
    k_nxt     = k_r;
    esum_nxt  = esum_r;
    m_nxt     = m_r;
    macc_nxt  = macc_r;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    mcnt_nxt  = mcnt_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          e_nxt     = 2'd0;
          k_nxt     = 2'd0;
          esum_nxt  = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        esum_nxt = esum_r + EW'(sq);
        k_nxt    = k_r + 2'd1;
        if (k_r == 2'd2) begin
          state_nxt = ST_ESS;
        end
      end
      ST_ESS: begin
        state_nxt = ST_EW;
      end
      ST_EW: begin
        if (!sq_busy) begin
          if (e_r == 2'd2) begin
            state_nxt = ST_SUM;
          end else begin
            e_nxt     = e_r + 2'd1;
            k_nxt     = 2'd0;
            esum_nxt  = '0;
            state_nxt = ST_SQ;
          end
        end
      end
      ST_SUM: begin
        macc_nxt  = '0;
        mc_nxt    = PW'(s_c);
        mp_nxt    = f_c[0];
        mcnt_nxt  = MW'(SW);
        m_nxt     = 2'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        macc_nxt = macc_add;
        mc_nxt   = mc_r << 1;
        mp_nxt   = mp_r >> 1;
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == MW'(1)) begin
          if (m_r == 2'd2) begin
            state_nxt = ST_ASS;
          end else begin
            m_nxt    = m_r + 2'd1;
            macc_nxt = '0;
            mc_nxt   = macc_add;
            mp_nxt   = f_r[2'(m_r + 2'd1)];
            mcnt_nxt = MW'(SW);
          end
        end
      end
      ST_ASS: begin
        state_nxt = ST_AW;
      end
      ST_AW: begin
        if (!sq_busy) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    k_r    <= k_nxt;
    esum_r <= esum_nxt;
    m_r    <= m_nxt;
    macc_r <= macc_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    mcnt_r <= mcnt_nxt;
    if (pop) begin
      d_r    <= q_data[9*CB-1:0];
      last_r <= q_data[9*CB];
    end
    if (state_r == ST_EW && !sq_busy) begin
      len_r[e_r] <= sq_root[LB-1:0];
    end
    if (state_r == ST_SUM) begin
      f_r <= f_c;
    end
    if (state_r == ST_AW) begin
      area_r <= area_c;
    end
    if (load_out) begin
      out_triangle_area   <= area_r;
      out_area_total      <= tot_c;
      out_total_saturated <= sat_c;
      out_is_final        <= last_r;
    end
  end

  // control state, running sum and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_r     <= '0;
      sat_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        acc_r     <= last_r ? '0 : tot_c;
        sat_r     <= last_r ? 1'b0 : sat_c;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (acc_r == '1))
    else $error("saturation flag set while sum below maximum");

  a_idle_root_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sq_busy)
    else $error("root unit busy while back part idle");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (mcnt_r != '0))
    else $error("multiply step count ran out");

  a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_SQ))
    else $error("popped entry not taken into edge pass");
`endif

endmodule

### verif/mesh_triangle_area_sum_top_test.sv
module mesh_triangle_area_sum_top_test;
  import mtas_pkg::*;

  localparam int CW         = 16;
  localparam int FRAC       = 4;
  localparam int N_RANDOM   = 650;
  localparam int STALL_LIM  = 20000;
  localparam int HOLD_LEN   = 1500;
  localparam logic [AREA_W-1:0] AREA_CAP = {AREA_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_CAP  = {SUM_W{1'b1}};

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t v[9];
    logic   last;
  } triangle_t;

  typedef struct {
    logic [AREA_W-1:0] area;
    logic [SUM_W-1:0]  total;
    logic              sat;
    logic              fin;
  } area_beat_t;

  // floor square root of a 128-bit value, one result bit at a time
  function automatic logic [63:0] root_floor(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= x) r = t;
    end
    return r;
  endfunction

  // edge length between two vertices, scaled to 2^-FRAC
  function automatic logic [63:0] edge_length(triangle_t t, int p, int q);
    logic [127:0] acc;
    logic [CW-1:0] u;
    logic [CW-1:0] w;
    logic [CW-1:0] d;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      u = {~t.v[p*3+k][CW-1], t.v[p*3+k][CW-2:0]};
      w = {~t.v[q*3+k][CW-1], t.v[q*3+k][CW-2:0]};
      d = (u > w) ? u - w : w - u;
      acc = acc + 128'(d) * 128'(d);
    end
    acc = acc << (2 * FRAC);
    return root_floor(acc);
  endfunction

  function automatic logic [127:0] heron_factor(logic [63:0] s, logic [63:0] e);
    logic [63:0] e2;
    e2 = e << 1;
    return (s > e2) ? 128'(s - e2) : 128'd0;
  endfunction

  class area_scoreboard;
    area_beat_t        pending[$];
    logic [SUM_W-1:0]  running_sum;
    logic              sum_stuck;
    int                errors;

    function new();
      running_sum = '0;
      sum_stuck   = 1'b0;
      errors      = 0;
    endfunction

    // predict the result for an accepted triangle
    function void note_triangle(triangle_t t);
      logic [63:0]  a;
      logic [63:0]  b;
      logic [63:0]  c;
      logic [63:0]  s;
      logic [127:0] prod;
      logic [63:0]  ar;
      logic [SUM_W-1:0] nsum;
      area_beat_t   e;
      a = edge_length(t, 0, 1);
      b = edge_length(t, 0, 2);
      c = edge_length(t, 2, 1);
      s = a + b + c;
      prod = 128'(s) * heron_factor(s, a);
      prod = prod * heron_factor(s, b);
      prod = prod * heron_factor(s, c);
      ar = root_floor(prod) >> 2;
      if (ar > 64'(AREA_CAP)) ar = 64'(AREA_CAP);
      nsum = running_sum + ar;
      if (nsum < running_sum) nsum = SUM_CAP;
      running_sum = nsum;
      if (nsum == SUM_CAP) sum_stuck = 1'b1;
      e.area  = ar[AREA_W-1:0];
      e.total = running_sum;
      e.sat   = sum_stuck;
      e.fin   = t.last;
      pending.insert(pending.size(), e);
      // clear the mesh sum after its final triangle
      if (t.last) begin
        running_sum = '0;
        sum_stuck   = 1'b0;
      end
    endfunction

    function void check_beat(area_beat_t got);
      area_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with no triangle outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.area !== e.area) begin
        $error("triangle_area expected %0d got %0d", e.area, got.area);
        errors++;
      end
      if (got.total !== e.total) begin
        $error("area_total expected %0d got %0d", e.total, got.total);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $error("total_saturated expected %0b got %0b", e.sat, got.sat);
        errors++;
      end
      if (got.fin !== e.fin) begin
        $error("is_final expected %0b got %0b", e.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  coord_t in_v[9];
  logic in_last_triangle;
  logic out_valid;
  logic out_ready;
  logic [AREA_W-1:0] out_triangle_area;
  logic [SUM_W-1:0]  out_area_total;
  logic out_total_saturated;
  logic out_is_final;

  area_scoreboard sb = new();
  int  sent_count;
  int  idle_cycles;
  bit  hold_done;

  mesh_triangle_area_sum_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_vert_a_x        (in_v[0]),
    .in_vert_a_y        (in_v[1]),
    .in_vert_a_z        (in_v[2]),
    .in_vert_b_x        (in_v[3]),
    .in_vert_b_y        (in_v[4]),
    .in_vert_b_z        (in_v[5]),
    .in_vert_c_x        (in_v[6]),
    .in_vert_c_y        (in_v[7]),
    .in_vert_c_z        (in_v[8]),
    .in_last_triangle   (in_last_triangle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_triangle_area  (out_triangle_area),
    .out_area_total     (out_area_total),
    .out_total_saturated(out_total_saturated),
    .out_is_final       (out_is_final)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // observe both channels at the edge
  always @(posedge clk) begin
    area_beat_t got;
    triangle_t  t;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        for (int k = 0; k < 9; k++) t.v[k] = in_v[k];
        t.last = in_last_triangle;
        sb.note_triangle(t);
      end
      if (out_valid && out_ready) begin
        got.area  = out_triangle_area;
        got.total = out_area_total;
        got.sat   = out_total_saturated;
        got.fin   = out_is_final;
        sb.check_beat(got);
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIM) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, mostly-ready stretches, and one long hold-off
  initial begin
    int mode;
    int len;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && sent_count >= 60) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 400);
      repeat (len) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // offer one triangle and hold it until taken
  task automatic send_triangle(triangle_t t);
    for (int k = 0; k < 9; k++) in_v[k] <= t.v[k];
    in_last_triangle <= t.last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_gap();
    int gap;
    gap = $urandom_range(0, 5) == 0 ? $urandom_range(1, 300) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic triangle_t make_random();
    triangle_t t;
    int mode;
    int k;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0: t.v[i] = coord_t'($urandom);
        1: t.v[i] = coord_t'($signed($urandom_range(0, 512)) - 256);
        default: t.v[i] = coord_t'($urandom);
      endcase
    end
    // nearly collinear: third vertex near the midpoint of the first two
    if (mode == 2) begin
      for (int i = 0; i < 3; i++) begin
        k = (int'(t.v[i]) + int'(t.v[3+i])) / 2 + $signed($urandom_range(0, 4)) - 2;
        t.v[6+i] = coord_t'(k);
      end
    end
    t.last = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  initial begin
    triangle_t t;
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_last_triangle = 1'b0;
    for (int k = 0; k < 9; k++) in_v[k] = '0;
    sent_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero, extremes, collinear, right triangle, last marks
    for (int d = 0; d < 12; d++) begin
      for (int k = 0; k < 9; k++) begin
        case (d)
          0: t.v[k] = '0;
          1: t.v[k] = (k < 3) ? 16'sh8000 : 16'sh7fff;
          2: t.v[k] = (k < 3) ? 16'sh8000 : (k < 6) ? 16'sh7fff : 16'sh8000;
          3: t.v[k] = (k % 3 == 0) ? coord_t'(16 * (k / 3)) : '0;
          4: t.v[k] = (k == 3) ? 16'sd48 : (k == 7) ? 16'sd64 : '0;
          5: t.v[k] = (k == 3 || k == 7 || k == 2) ? 16'sh7fff : 16'sh8000;
          6: t.v[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
          7: t.v[k] = (k / 3 == 1) ? 16'sh7fff : 16'sh8000;
          8: t.v[k] = (k == 3) ? 16'sd1 : (k == 7) ? 16'sd1 : '0;
          9: t.v[k] = coord_t'(-1);
          default: t.v[k] = coord_t'($urandom);
        endcase
      end
      t.last = (d == 2 || d == 6 || d == 9 || d == 11);
      send_triangle(t);
    end

    // random part in bursts
    while (sent_count < 12 + N_RANDOM) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        send_triangle(make_random());
      end
      send_gap();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
